[rtl/core/single_wire_sensor_reader_assert.svh]
// Assertion macros shared by the sensor reader RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SINGLE_WIRE_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_READER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SWSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SWSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swsr_pkg.sv]
// Shared types and constants of the single-wire sensor reader.
// No dependencies; all but swsr_in_if and the macro header import it.
package swsr_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int START_W     = 16;
  localparam int LIMIT_W     = 10;
  localparam int CMP_W       = (COUNT_WIDTH > START_W) ? COUNT_WIDTH : START_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAME_BITS  = 40;
  localparam int BIT_IDX_W   = 6;
  localparam int BYTE_W      = 8;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LIMIT_W-1:0]     limit_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [BYTE_W-1:0]      byte_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_START_LOW  = 3'd0;
  localparam cfg_idx_t REG_RELEASE    = 3'd1;
  localparam cfg_idx_t REG_RESP_LIMIT = 3'd2;
  localparam cfg_idx_t REG_LOW_LIMIT  = 3'd3;
  localparam cfg_idx_t REG_HIGH_LIMIT = 3'd4;
  localparam cfg_idx_t REG_ONE_THRESH = 3'd5;

  localparam logic [START_W-1:0] START_LOW_RST  = 16'd18000;
  localparam limit_t             RELEASE_RST    = 10'd40;
  localparam limit_t             RESP_LIMIT_RST = 10'd80;
  localparam limit_t             LOW_LIMIT_RST  = 10'd58;
  localparam limit_t             HIGH_LIMIT_RST = 10'd74;
  localparam limit_t             ONE_THRESH_RST = 10'd28;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_GOOD     = 2'd1,
    STAT_TIMEOUT  = 2'd2,
    STAT_CSUM_ERR = 2'd3
  } status_t;

  typedef struct packed {
    logic [START_W-1:0] start_low_ticks;
    limit_t             release_ticks;
    limit_t             response_limit;
    limit_t             bit_low_limit;
    limit_t             bit_high_limit;
    limit_t             one_threshold;
  } cfg_t;

  typedef struct packed {
    logic    drive_low;
    logic    busy_res;
    status_t status;
    byte_t   humidity_whole;
    byte_t   humidity_tenths;
    byte_t   temp_whole;
    byte_t   temp_tenths;
  } result_t;

endpackage

[rtl/core/swsr_in_if.sv]
// Input channel of the sensor reader: one tick with the sampled wire level.
// No dependencies.
interface swsr_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic start_request;

  modport source (output valid, output line_level, output start_request, input ready);
  modport sink   (input valid, input line_level, input start_request, output ready);
endinterface

[rtl/core/swsr_out_if.sv]
// Result channel of the sensor reader: one result per accepted tick.
// Depends on swsr_pkg for the status type.
interface swsr_out_if;
  import swsr_pkg::*;
  logic    valid;
  logic    ready;
  logic    drive_low;
  logic    busy_res;
  status_t status;
  byte_t   humidity_whole;
  byte_t   humidity_tenths;
  byte_t   temp_whole;
  byte_t   temp_tenths;

  modport source (output valid, output drive_low, output busy_res, output status,
                  output humidity_whole, output humidity_tenths, output temp_whole,
                  output temp_tenths, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input status,
                  input humidity_whole, input humidity_tenths, input temp_whole,
                  input temp_tenths, output ready);
endinterface

[rtl/core/swsr_cfg_if.sv]
// Configuration write channel of the sensor reader: register index and data.
// Depends on swsr_pkg for the index and data types.
interface swsr_cfg_if;
  import swsr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/swsr_cfg_regs.sv]
// Configuration register file of the sensor reader.
// Depends on swsr_pkg and swsr_cfg_if.
module swsr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  swsr_cfg_if.sink      cfg_ch,
  output swsr_pkg::cfg_t cfg
);
  import swsr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START_LOW:  cfg_nxt.start_low_ticks = cfg_ch.data[START_W-1:0];
        REG_RELEASE:    cfg_nxt.release_ticks   = cfg_ch.data[LIMIT_W-1:0];
        REG_RESP_LIMIT: cfg_nxt.response_limit  = cfg_ch.data[LIMIT_W-1:0];
        REG_LOW_LIMIT:  cfg_nxt.bit_low_limit   = cfg_ch.data[LIMIT_W-1:0];
        REG_HIGH_LIMIT: cfg_nxt.bit_high_limit  = cfg_ch.data[LIMIT_W-1:0];
        REG_ONE_THRESH: cfg_nxt.one_threshold   = cfg_ch.data[LIMIT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks <= START_LOW_RST;
      cfg_r.release_ticks   <= RELEASE_RST;
      cfg_r.response_limit  <= RESP_LIMIT_RST;
      cfg_r.bit_low_limit   <= LOW_LIMIT_RST;
      cfg_r.bit_high_limit  <= HIGH_LIMIT_RST;
      cfg_r.one_threshold   <= ONE_THRESH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/swsr_core.sv]
// Per-tick protocol engine: phase, tick counter, frame shifter and held bytes.
// Depends on swsr_pkg and the assertion macro header.
`include "single_wire_sensor_reader_assert.svh"

module swsr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             line_level,
  input  logic             start_request,
  input  swsr_pkg::cfg_t    cfg,
  output swsr_pkg::result_t res
);
  import swsr_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_DRIVE    = 8'b0000_0010,
    PH_RELEASE  = 8'b0000_0100,
    PH_RESP_A   = 8'b0000_1000,
    PH_RESP_B   = 8'b0001_0000,
    PH_RESP_C   = 8'b0010_0000,
    PH_BIT_LOW  = 8'b0100_0000,
    PH_BIT_HIGH = 8'b1000_0000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  count_t                  count_r, count_nxt;
  logic [BIT_IDX_W-1:0]    bit_idx_r, bit_idx_nxt;
  logic [FRAME_BITS-1:0]   frame_r, frame_nxt;
  logic [4*BYTE_W-1:0]     held_r, held_nxt;

  phase_t                  ph0, ph1, ph2, ph3, ph4;
  count_t                  c0, c1, c2, c3, c4;
  logic [BIT_IDX_W-1:0]    idx0, idx_inc;
  logic [FRAME_BITS-1:0]   frame0, frame_sh;
  logic                    is_wait, wait_lvl, new_bit;
  limit_t                  wait_lim;
  byte_t                   csum;
  logic                    drive;
  status_t                 status;

  always_comb begin
    // Start request in idle opens the start pulse on this very tick.
    ph0    = phase_r;
    c0     = count_r;
    idx0   = bit_idx_r;
    frame0 = frame_r;
    if (phase_r == PH_IDLE && start_request) begin
      ph0    = PH_DRIVE;
      c0     = '0;
      idx0   = '0;
      frame0 = '0;
    end

    // Leave the start pulse and the release gap once their time is used up.
    ph1 = ph0;
    c1  = c0;
    if (ph0 == PH_DRIVE && CMP_W'(c0) >= CMP_W'(cfg.start_low_ticks)) begin
      ph1 = PH_RELEASE;
      c1  = '0;
    end
    ph2 = ph1;
    c2  = c1;
    if (ph1 == PH_RELEASE && CMP_W'(c1) >= CMP_W'(cfg.release_ticks)) begin
      ph2 = PH_RESP_A;
      c2  = '0;
    end

    // A level change ends the current wait; the ending sample starts the next.
    is_wait   = (ph2 == PH_RESP_A) || (ph2 == PH_RESP_B) || (ph2 == PH_RESP_C) ||
                (ph2 == PH_BIT_LOW) || (ph2 == PH_BIT_HIGH);
    wait_lvl  = (ph2 == PH_RESP_B) || (ph2 == PH_BIT_HIGH);
    new_bit   = CMP_W'(c2) > CMP_W'(cfg.one_threshold);
    idx_inc   = idx0 + BIT_IDX_W'(1);
    frame_sh  = {frame0[FRAME_BITS-2:0], new_bit};
    csum      = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];
    ph3         = ph2;
    c3          = c2;
    bit_idx_nxt = idx0;
    frame_nxt   = frame0;
    held_nxt    = held_r;
    status      = STAT_NONE;
    if (is_wait && (line_level != wait_lvl)) begin
      c3 = '0;
      case (ph2)
        PH_RESP_A:  ph3 = PH_RESP_B;
        PH_RESP_B:  ph3 = PH_RESP_C;
        PH_RESP_C:  ph3 = PH_BIT_LOW;
        PH_BIT_LOW: ph3 = PH_BIT_HIGH;
        PH_BIT_HIGH: begin
          bit_idx_nxt = idx_inc;
          frame_nxt   = frame_sh;
          if (32'(idx_inc) >= FRAME_BITS) begin
            ph3 = PH_IDLE;
            if (csum == frame_sh[7:0]) begin
              status   = STAT_GOOD;
              held_nxt = frame_sh[FRAME_BITS-1:BYTE_W];
            end else begin
              status   = STAT_CSUM_ERR;
            end
          end else begin
            ph3 = PH_BIT_LOW;
          end
        end
        default: ph3 = ph2;
      endcase
    end

    // A bit low entered on a high sample falls straight through to bit high.
    ph4 = ph3;
    c4  = c3;
    if (ph3 == PH_BIT_LOW && line_level) begin
      ph4 = PH_BIT_HIGH;
    end

    // Count the tick in the phase that owns it, or time out.
    wait_lim  = (ph4 == PH_BIT_LOW)  ? cfg.bit_low_limit :
                (ph4 == PH_BIT_HIGH) ? cfg.bit_high_limit : cfg.response_limit;
    drive     = 1'b0;
    phase_nxt = ph4;
    count_nxt = c4;
    case (ph4)
      PH_IDLE: count_nxt = c4;
      PH_DRIVE: begin
        drive     = 1'b1;
        count_nxt = c4 + count_t'(1);
      end
      PH_RELEASE: count_nxt = c4 + count_t'(1);
      PH_RESP_A, PH_RESP_B, PH_RESP_C, PH_BIT_LOW, PH_BIT_HIGH: begin
        if (CMP_W'(c4) >= CMP_W'(wait_lim)) begin
          status    = STAT_TIMEOUT;
          phase_nxt = PH_IDLE;
          count_nxt = '0;
        end else begin
          count_nxt = c4 + count_t'(1);
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    res.drive_low       = drive;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.status          = status;
    res.humidity_whole  = held_nxt[31:24];
    res.humidity_tenths = held_nxt[23:16];
    res.temp_whole      = held_nxt[15:8];
    res.temp_tenths     = held_nxt[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= '0;
      bit_idx_r <= '0;
      frame_r   <= '0;
      held_r    <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      bit_idx_r <= bit_idx_nxt;
      frame_r   <= frame_nxt;
      held_r    <= held_nxt;
    end
  end

  `SWSR_ASSERT_NEXT(a_status_ends_read, step_en && (res.status != STAT_NONE), phase_r == PH_IDLE, "reading still busy after a final status")
  `SWSR_ASSERT_NOW(a_drive_is_busy, step_en && res.drive_low, res.busy_res, "start pulse driven while not busy")
  `SWSR_ASSERT_NOW(a_bit_idx_range, 1'b1, 32'(bit_idx_r) <= FRAME_BITS, "bit index ran past the frame")
  `SWSR_ASSERT_NEXT(a_held_only_good, !(step_en && (res.status == STAT_GOOD)), $stable(held_r), "held bytes changed without a good reading")

endmodule

[rtl/core/swsr_out_buf.sv]
// Two-entry result buffer: output register plus skid entry.
// Depends on swsr_pkg, swsr_out_if and the assertion macro header.
`include "single_wire_sensor_reader_assert.svh"

module swsr_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swsr_pkg::result_t push_data,
  output logic              space,
  swsr_out_if.source        out_ch
);
  import swsr_pkg::*;

  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    pop;

  assign space = !skid_valid_r;
  assign pop   = main_valid_r && out_ch.ready;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || pop) begin
      // Refill the output register, oldest transaction first.
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      // Output stalled: park the new transaction.
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = main_valid_r;
  assign out_ch.drive_low       = main_r.drive_low;
  assign out_ch.busy_res        = main_r.busy_res;
  assign out_ch.status          = main_r.status;
  assign out_ch.humidity_whole  = main_r.humidity_whole;
  assign out_ch.humidity_tenths = main_r.humidity_tenths;
  assign out_ch.temp_whole      = main_r.temp_whole;
  assign out_ch.temp_tenths     = main_r.temp_tenths;

  `SWSR_ASSERT_NOW(a_skid_behind_main, skid_valid_r, main_valid_r, "skid entry holds data ahead of the output register")
  `SWSR_ASSERT_NEXT(a_full_holds, skid_valid_r && !out_ch.ready, skid_valid_r && main_valid_r, "buffered transaction lost while stalled")
  `SWSR_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_r, "transaction pushed into a full buffer")

endmodule

[rtl/core/single_wire_sensor_reader.sv]
// Single-wire humidity/temperature sensor reader, one transaction per 1 us tick.
// Depends on swsr_pkg, the channel interfaces, swsr_cfg_regs, swsr_core, swsr_out_buf.
//
// Each input transaction is one microsecond sample of the open-drain wire plus a
// start request. A start in idle drives the wire low for start_low_ticks ticks,
// releases it for release_ticks ticks, then times the sensor response (low,
// high, low) and 40 data bits (low, then a timed high; longer than
// one_threshold is a one), MSB first. Each wait times out once its count has
// reached its limit. The tick that ends a reading reports good, timeout or
// checksum error in status; a good reading updates the four held bytes. Every
// input transaction yields exactly one result transaction. Rate: one input
// transaction per clock; the whole tick update is one pass of logic from the
// state registers back to themselves, and the result is registered in a
// two-entry output buffer, so input is refused only when two results are
// waiting. There is no clearing pass after reset. Write the configuration
// registers only while no reading is in progress.
module single_wire_sensor_reader (
  input  logic       clk,
  input  logic       rst_n,
  swsr_in_if.sink    in_ch,
  swsr_out_if.source out_ch,
  swsr_cfg_if.sink   cfg_ch
);
  import swsr_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    buf_space;
  logic    step_en;

  // Accept a tick whenever the result buffer has room for its result.
  assign in_ch.ready = buf_space;
  assign step_en     = in_ch.valid && buf_space;

  swsr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Advance phase, counter and frame once per accepted tick.
  swsr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .line_level    (in_ch.line_level),
    .start_request (in_ch.start_request),
    .cfg           (cfg),
    .res           (res)
  );

  // Hold results until the consumer takes them.
  swsr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_en),
    .push_data (res),
    .space     (buf_space),
    .out_ch    (out_ch)
  );

endmodule
